// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CHECK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_CHECK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// ===== rtl/cee_pkg.sv =====
package cee_pkg;

	localparam int unsigned VEC_W = 8;
	localparam int unsigned PRIO_W = 5;
	localparam int unsigned SR_W = 10;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned KIND_W = 2;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QIDX_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic ACT_ASSERT = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;

	localparam logic [3:0] MASK_ALL = 4'hF;
	localparam logic [PRIO_W-1:0] PRIO_MAX_MASK = 5'd15;

	localparam logic [VEC_W-1:0] VEC_ADDR_ERR_LO = 8'd9;
	localparam logic [VEC_W-1:0] VEC_ADDR_ERR_HI = 8'd10;
	localparam logic [VEC_W-1:0] VEC_IRQ_LO = 8'd11;
	localparam logic [VEC_W-1:0] VEC_IRQ_HI = 8'd12;
	localparam logic [VEC_W-1:0] VEC_EXT_IRQ = 8'd64;

	localparam logic [WORD_W-1:0] PUSH_STEP = 32'd4;
	localparam logic [WORD_W-1:0] PUSH_TWO = 32'd8;
	localparam logic [WORD_W-1:0] PC_BACK = 32'd2;

	typedef struct packed {
		logic take;
		logic [SR_W-1:0] status_word;
		logic [WORD_W-1:0] sp_first;
		logic [WORD_W-1:0] sp_second;
		logic [WORD_W-1:0] return_pc;
		logic [WORD_W-1:0] fetch_addr;
		logic [SR_W-1:0] new_status;
	} job_t;

	typedef struct packed {
		logic empty;
		job_t head;
	} queue_stat_t;

endpackage

// ===== rtl/cee_req_if.sv =====
interface cee_req_if;
	logic valid;
	logic ready;
	logic action;
	logic [cee_pkg::VEC_W-1:0] vec_num;
	logic [cee_pkg::PRIO_W-1:0] prio;
	logic [cee_pkg::SR_W-1:0] status_word;
	logic [cee_pkg::WORD_W-1:0] program_counter;
	logic [cee_pkg::WORD_W-1:0] stack_pointer;
	logic [cee_pkg::WORD_W-1:0] vector_base;
	logic pipe_valid;
	logic delay_slot;
	logic no_irq_slot;

	modport source (
		output valid, action, vec_num, prio, status_word, program_counter,
			stack_pointer, vector_base, pipe_valid, delay_slot, no_irq_slot,
		input ready
	);
	modport sink (
		input valid, action, vec_num, prio, status_word, program_counter,
			stack_pointer, vector_base, pipe_valid, delay_slot, no_irq_slot,
		output ready
	);
endinterface

// ===== rtl/cee_rsp_if.sv =====
interface cee_rsp_if;
	logic valid;
	logic ready;
	logic [cee_pkg::KIND_W-1:0] kind;
	logic [cee_pkg::WORD_W-1:0] bus_address;
	logic [cee_pkg::WORD_W-1:0] bus_data;
	logic [cee_pkg::SR_W-1:0] new_status;
	logic [cee_pkg::WORD_W-1:0] new_stack;
	logic last;

	modport source (
		output valid, kind, bus_address, bus_data, new_status, new_stack, last,
		input ready
	);
	modport sink (
		input valid, kind, bus_address, bus_data, new_status, new_stack, last,
		output ready
	);
endinterface

// ===== rtl/cee_front.sv =====
module cee_front (
	input logic clk,
	input logic arst_n,
	cee_req_if.sink req,
	input logic full,
	output logic push,
	output cee_pkg::job_t job
);

	logic [cee_pkg::VEC_W-1:0] pend_vec_q;
	logic [cee_pkg::PRIO_W-1:0] pend_prio_q;
	logic [3:0] imask;
	logic req_ok;
	logic addr_err;
	logic irq;
	logic may_take;
	logic take;
	logic [3:0] new_mask;

	assign req.ready = !full;
	assign push = req.valid && !full;

	assign imask = req.status_word[7:4];
	assign req_ok = (req.action == cee_pkg::ACT_ASSERT) && (imask != cee_pkg::MASK_ALL)
		&& ({1'b0, imask} < req.prio);

	assign addr_err = (pend_vec_q == cee_pkg::VEC_ADDR_ERR_LO)
		|| (pend_vec_q == cee_pkg::VEC_ADDR_ERR_HI);
	assign irq = (pend_vec_q == cee_pkg::VEC_IRQ_LO) || (pend_vec_q == cee_pkg::VEC_IRQ_HI)
		|| (pend_vec_q >= cee_pkg::VEC_EXT_IRQ);
	assign may_take = req.pipe_valid && !(req.delay_slot && (addr_err || irq))
		&& !(req.no_irq_slot && irq);
	assign take = (req.action == cee_pkg::ACT_CHECK) && (pend_vec_q != '0) && may_take;

	assign new_mask = (pend_prio_q > cee_pkg::PRIO_MAX_MASK) ? cee_pkg::MASK_ALL
		: pend_prio_q[3:0];

	always_comb begin
		job.take = take;
		job.status_word = req.status_word;
		job.sp_first = req.stack_pointer - cee_pkg::PUSH_STEP;
		job.sp_second = req.stack_pointer - cee_pkg::PUSH_TWO;
		job.return_pc = req.program_counter - cee_pkg::PC_BACK;
		job.fetch_addr = req.vector_base
			+ {{(cee_pkg::WORD_W - cee_pkg::VEC_W - 2){1'b0}}, pend_vec_q, 2'b00};
		job.new_status = {req.status_word[9:8], new_mask, req.status_word[3:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vec_q <= '0;
			pend_prio_q <= '0;
		end else if (push) begin
			if (req_ok) begin
				pend_vec_q <= req.vec_num;
				pend_prio_q <= req.prio;
			end else if (take) begin
				pend_vec_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/cee_queue.sv =====
module cee_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cee_pkg::job_t wr_job,
	input logic pop,
	output logic full,
	output cee_pkg::queue_stat_t stat
);

	cee_pkg::job_t mem_q [cee_pkg::QDEPTH];
	logic [cee_pkg::QIDX_W-1:0] wr_ptr_q;
	logic [cee_pkg::QIDX_W-1:0] rd_ptr_q;
	logic [cee_pkg::QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == cee_pkg::QCNT_W'(cee_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/cee_back.sv =====
`include "assert_macros.svh"

module cee_back (
	input logic clk,
	input logic arst_n,
	input cee_pkg::queue_stat_t stat,
	output logic pop,
	cee_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		STEP_SR,
		STEP_PC,
		STEP_VEC
	} step_t;

	step_t step_q;
	logic valid_q;
	logic [cee_pkg::KIND_W-1:0] kind_q;
	logic [cee_pkg::WORD_W-1:0] addr_q;
	logic [cee_pkg::WORD_W-1:0] data_q;
	logic [cee_pkg::SR_W-1:0] status_q;
	logic [cee_pkg::WORD_W-1:0] stack_q;
	logic last_q;

	logic load;
	logic last_n;
	logic [cee_pkg::KIND_W-1:0] kind_n;
	logic [cee_pkg::WORD_W-1:0] addr_n;
	logic [cee_pkg::WORD_W-1:0] data_n;
	logic [cee_pkg::SR_W-1:0] status_n;
	logic [cee_pkg::WORD_W-1:0] stack_n;
	step_t step_n;

	assign load = !stat.empty && (!valid_q || rsp.ready);

	always_comb begin
		kind_n = cee_pkg::KIND_NONE;
		addr_n = '0;
		data_n = '0;
		status_n = '0;
		stack_n = '0;
		last_n = 1'b1;
		step_n = STEP_SR;
		if (stat.head.take) begin
			unique case (step_q)
				STEP_SR: begin
					kind_n = cee_pkg::KIND_STACK;
					addr_n = stat.head.sp_first;
					data_n = {{(cee_pkg::WORD_W - cee_pkg::SR_W){1'b0}},
						stat.head.status_word};
					last_n = 1'b0;
					step_n = STEP_PC;
				end
				STEP_PC: begin
					kind_n = cee_pkg::KIND_STACK;
					addr_n = stat.head.sp_second;
					data_n = stat.head.return_pc;
					last_n = 1'b0;
					step_n = STEP_VEC;
				end
				STEP_VEC: begin
					kind_n = cee_pkg::KIND_FETCH;
					addr_n = stat.head.fetch_addr;
					status_n = stat.head.new_status;
					stack_n = stat.head.sp_second;
				end
				default: begin
					step_n = STEP_SR;
				end
			endcase
		end
	end

	assign pop = load && last_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_SR;
			valid_q <= 1'b0;
			kind_q <= cee_pkg::KIND_NONE;
			addr_q <= '0;
			data_q <= '0;
			status_q <= '0;
			stack_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= step_n;
				valid_q <= 1'b1;
				kind_q <= kind_n;
				addr_q <= addr_n;
				data_q <= data_n;
				status_q <= status_n;
				stack_q <= stack_n;
				last_q <= last_n;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.kind = kind_q;
	assign rsp.bus_address = addr_q;
	assign rsp.bus_data = data_q;
	assign rsp.new_status = status_q;
	assign rsp.new_stack = stack_q;
	assign rsp.last = last_q;

	`ASSERT_CHECK(a_step_has_job, clk, arst_n, (step_q != STEP_SR) |-> !stat.empty)
	`ASSERT_CHECK(a_pop_rewinds, clk, arst_n, pop |=> (step_q == STEP_SR))
	`ASSERT_CHECK(a_mid_entry_advances, clk, arst_n, (load && !pop) |=> (step_q != STEP_SR))
	`ASSERT_NEVER(a_fetch_not_last, clk, arst_n, valid_q && (kind_q == cee_pkg::KIND_FETCH) && !last_q)
	`ASSERT_NEVER(a_none_not_last, clk, arst_n, valid_q && (kind_q == cee_pkg::KIND_NONE) && !last_q)

endmodule

// ===== rtl/cpu_exception_entry_unit_top.sv =====
// Exception entry unit: req items are either assert requests, which may overwrite the single
// pending exception slot, or instruction boundary checks, which take the pending exception
// when the pipeline state allows it. Every item is accepted into a two-entry queue while
// the front end keeps the pending slot up to date, so req stays ready as long as the queue
// has room. The back end drains the queue through a registered rsp output: an assert
// request or a check that takes nothing yields one rsp item, and a taken exception yields
// three (two stack writes, then the vector fetch with the new status and stack pointer), one
// per cycle while rsp is ready. Sustained rate is one req item per cycle for one-result items
// while rsp is ready; an exception entry stays at the queue head until its three rsp items
// are loaded. An accepted req item is first written into the queue, and the back end then
// loads the rsp output register from the queue head.
module cpu_exception_entry_unit_top (
	input logic clk,
	input logic arst_n,
	cee_req_if.sink req,
	cee_rsp_if.source rsp
);

	logic full;
	logic push;
	logic pop;
	cee_pkg::job_t job;
	cee_pkg::queue_stat_t stat;

	cee_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.req (req),
		.full (full),
		.push (push),
		.job (job)
	);

	cee_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.wr_job (job),
		.pop (pop),
		.full (full),
		.stat (stat)
	);

	cee_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.stat (stat),
		.pop (pop),
		.rsp (rsp)
	);

endmodule
